// File: rtl/erp_pkg.sv
`timescale 1ns / 1ps
// Package for the Euler-angle point rotation block: payload types, fixed-point
// constants, step tables for the sine and cosine series, and shared arithmetic helpers.
// Depends on nothing; every file but erp_fifo imports it.
package erp_pkg;

  localparam int unsigned MidDepthDef = 4;
  localparam int unsigned OutDepthDef = 32;
  localparam int unsigned TrigLat = 18;
  localparam int unsigned BackLat = TrigLat + 6;
  localparam int unsigned GeomTaps = TrigLat + 4;
  localparam int unsigned Steps = 5;

  localparam logic signed [15:0] HalfPi = 16'sd12868;
  localparam logic signed [16:0] Pi = 17'sd25736;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  // Lane 0 is the sine series, lane 1 the cosine series. Each step but the first sine
  // step divides by 2^StepSh, then by an odd constant through a reciprocal multiply.
  localparam int unsigned StepSh [2][Steps] = '{'{0, 3, 1, 2, 1}, '{1, 3, 1, 2, 1}};
  localparam int unsigned StepS [2][Steps] = '{'{0, 36, 37, 35, 34}, '{38, 35, 36, 34, 0}};
  localparam logic [32:0] StepM [2][Steps] = '{
    '{33'd0,
      33'((64'd1 << 36) / 64'd9 + 64'd1),
      33'((64'd1 << 37) / 64'd21 + 64'd1),
      33'((64'd1 << 35) / 64'd5 + 64'd1),
      33'((64'd1 << 34) / 64'd3 + 64'd1)},
    '{33'((64'd1 << 38) / 64'd45 + 64'd1),
      33'((64'd1 << 35) / 64'd7 + 64'd1),
      33'((64'd1 << 36) / 64'd15 + 64'd1),
      33'((64'd1 << 34) / 64'd3 + 64'd1),
      33'd1}};

  typedef struct packed {
    logic signed [15:0] angle_a;
    logic signed [15:0] angle_b;
    logic signed [15:0] angle_c;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } erp_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
  } erp_out_t;

  typedef struct packed {
    logic [15:0] r;
    logic        flip;
  } erp_fold_t;

  typedef struct packed {
    logic [2:0][32:0] diff;
    logic [2:0][31:0] center;
  } erp_geom_t;

  typedef struct packed {
    erp_fold_t fold_a;
    erp_fold_t fold_b;
    erp_fold_t fold_c;
    erp_geom_t geom;
  } erp_work_t;

  typedef struct packed {
    logic [31:0] s;
    logic [31:0] c;
  } erp_trig_t;

  function automatic logic signed [31:0] clamp_unit(input logic signed [36:0] v);
    logic signed [31:0] res;
    if (v > 37'sd1073741824) begin
      res = OneQ30;
    end else if (v < -37'sd1073741824) begin
      res = -OneQ30;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] pr;
    pr = a * b;
    return pr[61:30];
  endfunction

  function automatic erp_fold_t fold_angle(input logic signed [15:0] a);
    logic signed [16:0] ax;
    logic signed [16:0] rx;
    erp_fold_t f;
    ax = 17'(a);
    if (a > HalfPi) begin
      rx = Pi - ax;
      f.flip = 1'b1;
    end else if (a < -HalfPi) begin
      rx = -Pi - ax;
      f.flip = 1'b1;
    end else begin
      rx = ax;
      f.flip = 1'b0;
    end
    f.r = rx[15:0];
    return f;
  endfunction

endpackage

// File: rtl/erp_fifo.sv
`timescale 1ns / 1ps
// Small first-in first-out queue with show-ahead read and a fill count.
// Depends on nothing.
module erp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [Width-1:0]               data_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic [Width-1:0]               data_o,
  output logic                           empty_o,
  output logic [$clog2(Depth+1)-1:0]     count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/erp_front.sv
`timescale 1ns / 1ps
// Front end: takes input requests, folds each angle into one half turn, forms the
// point minus center differences and queues the work for the back end.
// Depends on erp_pkg and erp_fifo.
module erp_front import erp_pkg::*; #(
  parameter int unsigned MidDepth = MidDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  erp_in_t   in_item_i,
  output logic      full_o,
  input  logic      issue_i,
  output erp_work_t work_o,
  output logic      work_valid_o
);

  erp_work_t                   work_d;
  logic [$bits(erp_work_t)-1:0] mid_data;
  logic                         mid_empty;

  always_comb begin
    work_d.fold_a = fold_angle(in_item_i.angle_a);
    work_d.fold_b = fold_angle(in_item_i.angle_b);
    work_d.fold_c = fold_angle(in_item_i.angle_c);
    work_d.geom.diff[0] = {in_item_i.point_x[31], in_item_i.point_x}
                          - {in_item_i.center_x[31], in_item_i.center_x};
    work_d.geom.diff[1] = {in_item_i.point_y[31], in_item_i.point_y}
                          - {in_item_i.center_y[31], in_item_i.center_y};
    work_d.geom.diff[2] = {in_item_i.point_z[31], in_item_i.point_z}
                          - {in_item_i.center_z[31], in_item_i.center_z};
    work_d.geom.center[0] = in_item_i.center_x;
    work_d.geom.center[1] = in_item_i.center_y;
    work_d.geom.center[2] = in_item_i.center_z;
  end

  erp_fifo #(
    .Width($bits(erp_work_t)),
    .Depth(MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (work_d),
    .full_o  (full_o),
    .pop_i   (issue_i),
    .data_o  (mid_data),
    .empty_o (mid_empty),
    .count_o ()
  );

  assign work_o       = mid_data;
  assign work_valid_o = !mid_empty;

endmodule

// File: rtl/erp_trig.sv
`timescale 1ns / 1ps
// Pipelined sine and cosine of one folded angle by truncated Taylor series in Q30.
// Depends on erp_pkg.
module erp_trig import erp_pkg::*; (
  input  logic      clk_i,
  input  erp_fold_t fold_i,
  output erp_trig_t trig_o
);

  typedef struct packed {
    logic [15:0] r;
    logic        flip;
    logic [32:0] x2;
  } meta_t;

  meta_t              meta_q [Steps*3+1];
  logic signed [35:0] p_q [2][Steps];
  logic [64:0]        prod_q [2][Steps];
  logic               neg_q [2][Steps];
  logic signed [32:0] t_q [2][Steps];
  logic signed [31:0] rsq;
  logic signed [48:0] rt;
  logic signed [35:0] sin_raw_q;
  logic signed [31:0] cos_cl;
  logic signed [31:0] cos_q;
  erp_trig_t          trig_q;

  assign rsq = $signed(fold_i.r) * $signed(fold_i.r);

  always_ff @(posedge clk_i) begin
    meta_q[0].r    <= fold_i.r;
    meta_q[0].flip <= fold_i.flip;
    meta_q[0].x2   <= {1'b0, rsq[27:0], 4'b0000};
    for (int j = 1; j < Steps*3+1; j++) begin
      meta_q[j] <= meta_q[j-1];
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    for (genvar k = 0; k < Steps; k++) begin : g_step
      logic signed [32:0] t_in;
      logic signed [65:0] px;
      logic signed [35:0] abs_p;
      logic [31:0]        mag;
      logic [64:0]        qfull;
      logic [31:0]        q;
      logic signed [32:0] q_s;

      if (k == 0) begin : g_first
        assign t_in = 33'sd1073741824;
      end else begin : g_next
        assign t_in = t_q[ln][k-1];
      end

      assign px    = $signed(meta_q[3*k].x2) * t_in;
      assign abs_p = p_q[ln][k][35] ? -p_q[ln][k] : p_q[ln][k];
      assign mag   = 32'(abs_p >> StepSh[ln][k]);
      assign qfull = prod_q[ln][k] >> StepS[ln][k];
      assign q     = qfull[31:0];
      assign q_s   = neg_q[ln][k] ? -$signed({1'b0, q}) : $signed({1'b0, q});

      always_ff @(posedge clk_i) begin
        p_q[ln][k]    <= px[65:30];
        neg_q[ln][k]  <= p_q[ln][k][35];
        prod_q[ln][k] <= mag * StepM[ln][k];
        t_q[ln][k]    <= 33'sd1073741824 - q_s;
      end
    end
  end

  assign rt     = $signed(meta_q[Steps*3].r) * t_q[0][Steps-1];
  assign cos_cl = clamp_unit({{4{t_q[1][Steps-1][32]}}, t_q[1][Steps-1]});

  always_ff @(posedge clk_i) begin
    sin_raw_q <= rt[48:13];
    cos_q     <= meta_q[Steps*3].flip ? -cos_cl : cos_cl;
    trig_q.s  <= clamp_unit({sin_raw_q[35], sin_raw_q});
    trig_q.c  <= cos_q;
  end

  assign trig_o = trig_q;

endmodule

// File: rtl/erp_back.sv
`timescale 1ns / 1ps
// Back end: issues queued work under output credit, builds the rotation matrix and
// forms center plus matrix times difference with rounding and saturation.
// Depends on erp_pkg and erp_trig.
module erp_back import erp_pkg::*; #(
  parameter int unsigned OutDepth = OutDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  erp_work_t                       work_i,
  input  logic                            work_valid_i,
  output logic                            issue_o,
  input  logic [$clog2(OutDepth+1)-1:0]   out_count_i,
  output erp_out_t                        res_o,
  output logic                            res_valid_o
);

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  logic [CntW-1:0]    inflight_q, inflight_d;
  logic               vld_q [BackLat];
  erp_geom_t          geom_q [GeomTaps];
  erp_trig_t          ta, tb, tg;
  logic signed [31:0] p_q [10];
  logic signed [31:0] nsb_q, sg_q, cg_q;
  logic signed [31:0] e_q [9];
  logic signed [31:0] f_q [4];
  logic signed [31:0] m_q [9];
  logic signed [64:0] mprod [9];
  logic signed [60:0] pr_q [9];
  logic signed [62:0] acc [3];
  logic signed [35:0] sum_d [3];
  logic signed [35:0] sum_q [3];
  logic signed [31:0] sat [3];
  erp_out_t           res_q;

  assign issue_o = work_valid_i
                   && (({1'b0, inflight_q} + {1'b0, out_count_i}) < (CntW+1)'(OutDepth));

  always_comb begin
    case ({issue_o, vld_q[BackLat-1]})
      2'b10:   inflight_d = inflight_q + 1'b1;
      2'b01:   inflight_d = inflight_q - 1'b1;
      default: inflight_d = inflight_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      for (int j = 0; j < BackLat; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else begin
      inflight_q <= inflight_d;
      vld_q[0]   <= issue_o;
      for (int j = 1; j < BackLat; j++) begin
        vld_q[j] <= vld_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    geom_q[0] <= work_i.geom;
    for (int j = 1; j < GeomTaps; j++) begin
      geom_q[j] <= geom_q[j-1];
    end
  end

  erp_trig u_trig_a (.clk_i(clk_i), .fold_i(work_i.fold_a), .trig_o(ta));
  erp_trig u_trig_b (.clk_i(clk_i), .fold_i(work_i.fold_b), .trig_o(tb));
  erp_trig u_trig_g (.clk_i(clk_i), .fold_i(work_i.fold_c), .trig_o(tg));

  always_ff @(posedge clk_i) begin
    p_q[0] <= mul_q30(ta.c, tb.c);
    p_q[1] <= mul_q30(ta.c, tb.s);
    p_q[2] <= mul_q30(ta.s, tb.s);
    p_q[3] <= mul_q30(ta.s, tb.c);
    p_q[4] <= mul_q30(ta.s, tg.c);
    p_q[5] <= mul_q30(ta.s, tg.s);
    p_q[6] <= mul_q30(ta.c, tg.c);
    p_q[7] <= mul_q30(ta.c, tg.s);
    p_q[8] <= mul_q30(tb.c, tg.s);
    p_q[9] <= mul_q30(tb.c, tg.c);
    nsb_q  <= -$signed(tb.s);
    sg_q   <= tg.s;
    cg_q   <= tg.c;

    e_q[0] <= p_q[0];
    e_q[1] <= mul_q30(p_q[1], sg_q);
    e_q[2] <= mul_q30(p_q[1], cg_q);
    e_q[3] <= p_q[3];
    e_q[4] <= mul_q30(p_q[2], sg_q);
    e_q[5] <= mul_q30(p_q[2], cg_q);
    e_q[6] <= nsb_q;
    e_q[7] <= p_q[8];
    e_q[8] <= p_q[9];
    f_q[0] <= p_q[4];
    f_q[1] <= p_q[5];
    f_q[2] <= p_q[6];
    f_q[3] <= p_q[7];

    m_q[0] <= clamp_unit(37'(e_q[0]));
    m_q[1] <= clamp_unit(37'(e_q[1]) - 37'(f_q[0]));
    m_q[2] <= clamp_unit(37'(e_q[2]) + 37'(f_q[1]));
    m_q[3] <= clamp_unit(37'(e_q[3]));
    m_q[4] <= clamp_unit(37'(e_q[4]) + 37'(f_q[2]));
    m_q[5] <= clamp_unit(37'(e_q[5]) - 37'(f_q[3]));
    m_q[6] <= clamp_unit(37'(e_q[6]));
    m_q[7] <= clamp_unit(37'(e_q[7]));
    m_q[8] <= clamp_unit(37'(e_q[8]));
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mprod[3*r+c] = m_q[3*r+c] * $signed(geom_q[GeomTaps-2].diff[c]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      acc[r] = 63'(pr_q[3*r]) + 63'(pr_q[3*r+1]) + 63'(pr_q[3*r+2]) + 63'sd134217728;
      sum_d[r] = 36'($signed(acc[r][62:28])) + 36'($signed(geom_q[GeomTaps-1].center[r]));
      if (sum_q[r] > 36'sd2147483647) begin
        sat[r] = 32'sh7fffffff;
      end else if (sum_q[r] < -36'sd2147483648) begin
        sat[r] = 32'sh80000000;
      end else begin
        sat[r] = sum_q[r][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      pr_q[i] <= mprod[i][62:2];
    end
    for (int r = 0; r < 3; r++) begin
      sum_q[r] <= sum_d[r];
    end
    res_q.rotated_x <= sat[0];
    res_q.rotated_y <= sat[1];
    res_q.rotated_z <= sat[2];
  end

  assign res_o       = res_q;
  assign res_valid_o = vld_q[BackLat-1];

endmodule

// File: rtl/euler_rotate_point_about_center.sv
`timescale 1ns / 1ps
// A request passes the middle queue, the back-end pipeline and the result queue.
// Throughput: one request per cycle while results are popped; the 32-entry result
// queue gives credit to the 24-stage back-end pipeline and sets the sustained rate.
// Reset is asynchronous and active low; it empties both queues and the pipeline.
// Depends on erp_pkg, erp_front, erp_back and erp_fifo.
module euler_rotate_point_about_center import erp_pkg::*; #(
  parameter int unsigned MidDepth = MidDepthDef,
  parameter int unsigned OutDepth = OutDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  erp_in_t  in_item_i,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output erp_out_t out_item_o
);

  erp_work_t                     work;
  logic                          work_valid;
  logic                          issue;
  erp_out_t                      res;
  logic                          res_valid;
  logic [$clog2(OutDepth+1)-1:0] out_count;
  logic [$bits(erp_out_t)-1:0]   out_data;

  erp_front #(
    .MidDepth(MidDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_item_i    (in_item_i),
    .full_o       (full),
    .issue_i      (issue),
    .work_o       (work),
    .work_valid_o (work_valid)
  );

  erp_back #(
    .OutDepth(OutDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_i       (work),
    .work_valid_i (work_valid),
    .issue_o      (issue),
    .out_count_i  (out_count),
    .res_o        (res),
    .res_valid_o  (res_valid)
  );

  erp_fifo #(
    .Width($bits(erp_out_t)),
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_item_o = out_data;

endmodule

// File: rtl/erp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the point rotation block, bound to the top level.
// Depends on erp_pkg and euler_rotate_point_about_center.
module erp_checker import erp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input erp_out_t out_item_o
);

  logic [31:0] pend_q, pend_d;

  always_comb begin
    case ({push && !full, pop && !empty})
      2'b10:   pend_d = pend_q + 1'b1;
      2'b01:   pend_d = pend_q - 1'b1;
      default: pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("Result queue is not empty after reset.");

  a_reset_not_full: assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("Input side is full after reset.");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 32'd0) |-> empty)
    else $error("A result appeared without an outstanding request.");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("A waiting result changed or vanished.");

endmodule

bind euler_rotate_point_about_center erp_checker u_erp_checker (.*);
